>>> hdl/elu_pkg.sv
package elu_pkg;

  // sample and coefficient formats
  localparam int SAMPLE_W  = 16;
  localparam int ALPHA_W   = 15;
  localparam int FRAC_W    = 12;
  localparam int EXP_W     = 17;
  localparam int LOG2E_W   = 15;
  localparam int U_W       = 16;
  localparam int K_W       = U_W - FRAC_W;
  localparam int MAG_W     = 18;

  // fixed-point constants
  localparam logic [LOG2E_W-1:0] LOG2E_Q14   = 15'd23637;
  localparam logic [31:0]        LN2_Q32     = 32'd2977044472;
  localparam logic [EXP_W-1:0]   ONE_Q16     = 17'd65536;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 15'd4096;

  // saturation bounds as magnitudes
  localparam logic [MAG_W-1:0] POS_LIMIT = MAG_W'((2 ** (SAMPLE_W - 1)) - 1);
  localparam logic [MAG_W-1:0] NEG_LIMIT = MAG_W'(2 ** (SAMPLE_W - 1));

  // request type codes
  localparam logic REQ_FWD = 1'b0;
  localparam logic REQ_BWD = 1'b1;

  typedef struct packed {
    logic                       req_type;
    logic signed [SAMPLE_W-1:0] x_value;
    logic signed [SAMPLE_W-1:0] err_value;
  } elu_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] y_value;
    logic                       saturated;
  } elu_out_t;

  // per-request side data carried along the pipe
  typedef struct packed {
    logic                       req_type;
    logic                       neg;
    logic signed [SAMPLE_W-1:0] pass_value;
  } elu_side_t;

  typedef struct packed {
    elu_side_t        side;
    logic [EXP_W-1:0] exp_q16;
  } elu_exp_t;

endpackage

>>> hdl/elu_activation_unit.sv
// ELU activation unit, one signed Q4.12 sample per request.
// Request channel (req_valid / req_ready / req_data): req_type selects the
// forward activation or the derivative times error; x_value is the sample
// and err_value the error sample, which forward requests ignore.
// Result channel (res_valid / res_ready / res_data): y_value, saturated to
// 16 bits, and a flag that is set when clipping happened.
// cfg_we / cfg_wdata write the alpha gain (unsigned Q3.12); write it only
// while no request is in flight.
// Pipeline: seven register stages, the last of them the output register.
// Throughput: one request per cycle unless the receiver stalls. Each stage
// holds at most one multiply; the fraction table is read through a
// registered port in stage three.
// Reset clears all stage valid bits and sets alpha to 1.0; nothing else
// needs clearing, the table is constant.
// When the receiver stalls, the output register holds its result and each
// stage holds once its successor is full; empty stages keep filling, so
// req_ready stays high until the pipe is full.
module elu_activation_unit
  import elu_pkg::*;
#(
  parameter int EXP_TABLE_ENTRIES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  elu_in_t            req_data,
  output logic               res_valid,
  input  logic               res_ready,
  output elu_out_t           res_data,
  input  logic               cfg_we,
  input  logic [ALPHA_W-1:0] cfg_wdata
);

  logic [ALPHA_W-1:0] alpha;
  logic               exp_valid;
  logic               exp_ready;
  elu_exp_t           exp_data;

  // alpha gain register
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= ALPHA_RESET;
    end else if (cfg_we) begin
      alpha <= cfg_wdata;
    end
  end

  // exp approximation stages
  elu_exp_unit #(
    .EXP_TABLE_ENTRIES(EXP_TABLE_ENTRIES)
  ) u_exp (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .exp_valid (exp_valid),
    .exp_ready (exp_ready),
    .exp_data  (exp_data)
  );

  // scaling, rounding and saturation stages
  elu_scale_unit u_scale (
    .clk       (clk),
    .rst       (rst),
    .alpha     (alpha),
    .exp_valid (exp_valid),
    .exp_ready (exp_ready),
    .exp_data  (exp_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

endmodule

>>> hdl/elu_exp_unit.sv
module elu_exp_unit
  import elu_pkg::*;
#(
  parameter int EXP_TABLE_ENTRIES = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  elu_in_t  req_data,
  output logic     exp_valid,
  input  logic     exp_ready,
  output elu_exp_t exp_data
);

  localparam int IW = $clog2(EXP_TABLE_ENTRIES);
  localparam int AW = $clog2(EXP_TABLE_ENTRIES + 1);
  localparam int PW = FRAC_W + IW;
  localparam int UPW = SAMPLE_W + LOG2E_W;
  localparam int TW = EXP_W + FRAC_W;

  // one table entry, round(65536 * 2^(-i/N)) via a Q32 series
  function automatic logic [EXP_W-1:0] exp_entry(input int unsigned i);
    logic [63:0] a;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] prod;
    a    = (64'(i) * 64'(LN2_Q32)) / EXP_TABLE_ENTRIES;
    sum  = 64'd1 << 32;
    term = 64'd1 << 32;
    for (int n = 1; n <= 16; n++) begin
      prod = (term * a) >> 32;
      case (n)
        1:       term = prod;
        2:       term = prod / 2;
        3:       term = prod / 3;
        4:       term = prod / 4;
        5:       term = prod / 5;
        6:       term = prod / 6;
        7:       term = prod / 7;
        8:       term = prod / 8;
        9:       term = prod / 9;
        10:      term = prod / 10;
        11:      term = prod / 11;
        12:      term = prod / 12;
        13:      term = prod / 13;
        14:      term = prod / 14;
        15:      term = prod / 15;
        16:      term = prod / 16;
        default: term = prod;
      endcase
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return EXP_W'((sum + 64'd32768) >> 16);
  endfunction

  // constant fraction table
  logic [EXP_W-1:0] exp_rom [EXP_TABLE_ENTRIES+1];

  for (genvar gi = 0; gi <= EXP_TABLE_ENTRIES; gi++) begin : g_rom
    assign exp_rom[gi] = exp_entry(gi);
  end

  // stage registers
  logic                v1, v2, v3, v4;
  elu_side_t           side1, side2, side3, side4;
  logic [U_W-1:0]      u1;
  logic [K_W-1:0]      k2, k3;
  logic [IW-1:0]       idx2;
  logic [FRAC_W-1:0]   r2, r3;
  logic [EXP_W-1:0]    hi3, lo3;
  logic [EXP_W-1:0]    ex4;
  logic                rdy1, rdy2, rdy3, rdy4;

  // stall chain: a stage loads when it is empty or its successor moves
  assign rdy4 = !v4 || exp_ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign req_ready = rdy1;

  // stage 1: negated sample (the magnitude of a negative one) times log2(e)
  logic [SAMPLE_W-1:0] abs_x;
  logic [UPW-1:0]      u_prod;
  elu_side_t           side0;

  assign abs_x  = SAMPLE_W'(~req_data.x_value) + SAMPLE_W'(1);
  assign u_prod = UPW'(abs_x) * UPW'(LOG2E_Q14) + UPW'(8192);
  assign side0.req_type   = req_data.req_type;
  assign side0.neg        = req_data.x_value[SAMPLE_W-1];
  assign side0.pass_value = (req_data.req_type == REQ_BWD) ? req_data.err_value
                                                           : req_data.x_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= req_valid;
    end
    if (rdy1) begin
      side1 <= side0;
      u1    <= U_W'(u_prod >> 14);
    end
  end

  // stage 2: split into shift and table position
  logic [PW-1:0] pos;

  assign pos = PW'(u1[FRAC_W-1:0]) * PW'(EXP_TABLE_ENTRIES);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2) begin
      side2 <= side1;
      k2    <= u1[U_W-1:FRAC_W];
      idx2  <= pos[PW-1:FRAC_W];
      r2    <= pos[FRAC_W-1:0];
    end
  end

  // stage 3: registered table read of both neighbors
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
    if (rdy3) begin
      side3 <= side2;
      k3    <= k2;
      r3    <= r2;
      hi3   <= exp_rom[AW'(idx2)];
      lo3   <= exp_rom[AW'(idx2) + AW'(1)];
    end
  end

  // stage 4: interpolate and apply the integer shift
  logic [EXP_W-1:0] diff;
  logic [TW-1:0]    step;
  logic [EXP_W-1:0] interp;

  assign diff   = (hi3 > lo3) ? (hi3 - lo3) : '0;
  assign step   = TW'(diff) * TW'(r3) + TW'(2048);
  assign interp = hi3 - EXP_W'(step >> FRAC_W);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= v3;
    end
    if (rdy4) begin
      side4 <= side3;
      ex4   <= interp >> k3;
    end
  end

  assign exp_valid        = v4;
  assign exp_data.side    = side4;
  assign exp_data.exp_q16 = ex4;

endmodule

>>> hdl/elu_scale_unit.sv
module elu_scale_unit
  import elu_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [ALPHA_W-1:0] alpha,
  input  logic               exp_valid,
  output logic               exp_ready,
  input  elu_exp_t           exp_data,
  output logic               res_valid,
  input  logic               res_ready,
  output elu_out_t           res_data
);

  localparam int PROD_W = ALPHA_W + EXP_W;
  localparam int BIG_W  = PROD_W + SAMPLE_W;

  logic                       v5, v6, v7;
  elu_side_t                  side5, side6;
  logic [PROD_W-1:0]          prod5;
  logic [MAG_W-1:0]           mag6;
  logic signed [SAMPLE_W-1:0] y7;
  logic                       sat7;
  logic                       rdy5, rdy6, rdy7;

  // stall chain
  assign rdy7 = !v7 || res_ready;
  assign rdy6 = !v6 || rdy7;
  assign rdy5 = !v5 || rdy6;
  assign exp_ready = rdy5;

  // stage 5: alpha times exp or one minus exp
  logic [EXP_W-1:0] factor;

  assign factor = (exp_data.side.req_type == REQ_BWD) ? exp_data.exp_q16
                                                       : (ONE_Q16 - exp_data.exp_q16);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (rdy5) begin
      v5 <= exp_valid;
    end
    if (rdy5) begin
      side5 <= exp_data.side;
      prod5 <= PROD_W'(alpha) * PROD_W'(factor);
    end
  end

  // stage 6: error scaling and rounding of the magnitude
  logic [SAMPLE_W-1:0] err_mag;
  logic [PROD_W:0]     fwd_sum;
  logic [BIG_W-1:0]    bwd_sum;
  logic [MAG_W-1:0]    mag;

  assign err_mag = side5.pass_value[SAMPLE_W-1] ?
                   (SAMPLE_W'(~side5.pass_value) + SAMPLE_W'(1)) :
                   SAMPLE_W'(side5.pass_value);
  assign fwd_sum = (PROD_W + 1)'(prod5) + (PROD_W + 1)'(32768);
  assign bwd_sum = BIG_W'(prod5) * BIG_W'(err_mag) + (BIG_W'(1) << 27);

  always_comb begin
    if (!side5.neg) begin
      mag = '0;
    end else if (side5.req_type == REQ_BWD) begin
      mag = MAG_W'(bwd_sum >> 28);
    end else begin
      mag = MAG_W'(fwd_sum >> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (rdy6) begin
      v6 <= v5;
    end
    if (rdy6) begin
      side6 <= side5;
      mag6  <= mag;
    end
  end

  // stage 7: sign and saturation into the output register
  logic                       res_neg;
  logic signed [SAMPLE_W-1:0] y_next;
  logic                       sat_next;

  assign res_neg = (side6.req_type == REQ_FWD) || side6.pass_value[SAMPLE_W-1];

  always_comb begin
    y_next   = side6.pass_value;
    sat_next = 1'b0;
    if (side6.neg) begin
      if (res_neg) begin
        if (mag6 > NEG_LIMIT) begin
          y_next   = SAMPLE_W'(-NEG_LIMIT);
          sat_next = 1'b1;
        end else begin
          y_next = SAMPLE_W'(-mag6);
        end
      end else begin
        if (mag6 > POS_LIMIT) begin
          y_next   = SAMPLE_W'(POS_LIMIT);
          sat_next = 1'b1;
        end else begin
          y_next = SAMPLE_W'(mag6);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (rdy7) begin
      v7 <= v6;
    end
    if (rdy7) begin
      y7   <= y_next;
      sat7 <= sat_next;
    end
  end

  assign res_valid          = v7;
  assign res_data.y_value   = y7;
  assign res_data.saturated = sat7;

`ifndef SYNTHESIS
  // forward magnitude never exceeds the positive limit
  a_fwd_in_range: assert property (@(posedge clk) disable iff (rst)
    v6 && side6.req_type == REQ_FWD |-> mag6 <= POS_LIMIT)
    else $error("forward magnitude out of range");

  // a clipped result sits on one of the two bounds
  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    v7 && sat7 |-> (y7 == SAMPLE_W'(POS_LIMIT) || y7 == SAMPLE_W'(-NEG_LIMIT)))
    else $error("saturated result not on a bound");

  // exp approximation never exceeds one
  a_exp_le_one: assert property (@(posedge clk) disable iff (rst)
    exp_valid |-> exp_data.exp_q16 <= ONE_Q16)
    else $error("exp value above one");

  // the output register holds its result while the receiver stalls
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    v7 && !res_ready |=> v7 && $stable(y7) && $stable(sat7))
    else $error("output register overwritten while stalled");
`endif

endmodule
